// ===== sv/spm_pkg.sv =====
// Package for the stereo pan mixer: mode codes, fixed-point constants and
// the 2^-k/16 table used by the attenuation interpolator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spm_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int PAN_WIDTH_DEF    = 16;

	// 0.2 * log2(e) in Q.16, scaled against the Q.12 pan position
	localparam int EXP_K = 18910;
	// 1.0 in Q.16
	localparam int ONE_Q16 = 65536;

	typedef enum logic [1:0] {
		MODE_STEREO_REPLACE = 2'd0,
		MODE_STEREO_ACC     = 2'd1,
		MODE_MONO_ACC       = 2'd2,
		MODE_MONO_ACC_ALT   = 2'd3
	} mode_t;

	// round(65536 * 2^(-k/16)) for k = 0..16
	function automatic logic [16:0] pow2_at(input logic [4:0] k);
		logic [16:0] v;
		unique case (k)
			5'd0:    v = 17'd65536;
			5'd1:    v = 17'd62757;
			5'd2:    v = 17'd60097;
			5'd3:    v = 17'd57549;
			5'd4:    v = 17'd55109;
			5'd5:    v = 17'd52773;
			5'd6:    v = 17'd50535;
			5'd7:    v = 17'd48393;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd44376;
			5'd10:   v = 17'd42495;
			5'd11:   v = 17'd40693;
			5'd12:   v = 17'd38968;
			5'd13:   v = 17'd37316;
			5'd14:   v = 17'd35734;
			5'd15:   v = 17'd34219;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/stereo_pan_mixer.sv =====
// Stereo pan mixer top level: pan law, attenuation and 2x2 mix, fully pipelined.
// Depends on spm_pkg.
`timescale 1ns / 1ps
// One request enters per clock and one result leaves per clock while the
// output side does not stall; the block is a 23-stage pipeline. The depth
// is set by the pan divider, which produces one quotient bit per stage (16
// stages) for |p|/(1+|p|); the attenuation exp(-0.2|p|) is a table lookup
// with linear interpolation that runs alongside the divider. A stall on the
// output freezes the whole pipeline in place and in_ready falls, so nothing
// is dropped or repeated. Mode 0 replaces the stereo pair, mode 1 adds the
// mix onto acc_left/acc_right, mode 2 (and the unused code 3) pans the mono
// sample in left_in onto the accumulators. Outputs saturate to the signed
// sample range. There are no configuration registers and no state between
// requests.
`default_nettype none
module stereo_pan_mixer
	import spm_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int PAN_WIDTH    = PAN_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [1:0]                    mode,
	input  wire  signed [PAN_WIDTH-1:0]   pan_value,
	input  wire  signed [SAMPLE_WIDTH-1:0] left_in,
	input  wire  signed [SAMPLE_WIDTH-1:0] right_in,
	input  wire  signed [SAMPLE_WIDTH-1:0] acc_left,
	input  wire  signed [SAMPLE_WIDTH-1:0] acc_right,
	input  wire                           last_in,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] out_left,
	output logic signed [SAMPLE_WIDTH-1:0] out_right,
	output logic                          last_out
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int PW = PAN_WIDTH;
	localparam int DW = PW + 1;                      // divisor 4096 + |p|
	localparam int YW = (PW + 3 > 17) ? PW + 3 : 17; // exponent argument, Q.16
	localparam int NQ = 16;                          // quotient bits
	localparam int MLW = SW + 5;                     // rounded mix
	localparam int PRW = SW + 23;                    // mix times attenuation
	localparam int YOW = SW + 8;                     // result before saturation

	typedef struct packed {
		logic [1:0]             md;
		logic                   neg;
		logic                   last;
		logic signed [SW-1:0]   xl;
		logic signed [SW-1:0]   xr;
		logic signed [SW-1:0]   al;
		logic signed [SW-1:0]   ar;
		logic [PW-1:0]          a;
		logic [DW-1:0]          den;
		logic [DW-1:0]          rem;
		logic [15:0]            lo;
		logic [NQ-1:0]          q;
		logic [YW-1:0]          y;
		logic [16:0]            m;
		logic [16:0]            mul;
		logic signed [19:0]     w0;
		logic signed [19:0]     w1;
		logic signed [19:0]     w2;
		logic signed [19:0]     w3;
		logic signed [SW+19:0]  p0;
		logic signed [SW+19:0]  p1;
		logic signed [SW+19:0]  p2;
		logic signed [SW+19:0]  p3;
		logic signed [MLW-1:0]  mll;
		logic signed [MLW-1:0]  mlr;
		logic signed [PRW-1:0]  prl;
		logic signed [PRW-1:0]  prr;
		logic signed [SW-1:0]   ol;
		logic signed [SW-1:0]   orr;
	} item_t;

	// Global advance: the whole pipe moves when the output stage is empty or its result is taken.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	item_t s1_d, s1, s2_d, s2, s3_d, s3, s4_d, s4, s5_d, s5, s6_d, s6, s7_d, s7;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	item_t dv_d [NQ];
	item_t dv_s [NQ];
	logic  dv_v [NQ];

	// Stage 1: capture the request, take |p| and form the divisor.
	always_comb begin
		s1_d      = '0;
		s1_d.md   = mode;
		s1_d.neg  = pan_value[PW-1];
		s1_d.last = last_in;
		s1_d.xl   = left_in;
		s1_d.xr   = right_in;
		s1_d.al   = acc_left;
		s1_d.ar   = acc_right;
		s1_d.a    = pan_value[PW-1] ? (~pan_value + PW'(1)) : pan_value;
		s1_d.den  = {1'b0, s1_d.a} + DW'(4096);
	end

	// Stage 2: rounded dividend split into remainder seed and low bits; exp argument.
	logic [PW+16:0] num;
	logic [PW+14:0] ak;
	always_comb begin
		s2_d   = s1;
		num    = {s1.a, 16'd0} + (PW+17)'(s1.den >> 1);
		s2_d.rem = num[PW+16:16];
		s2_d.lo  = num[15:0];
		s2_d.q   = '0;
		ak       = (PW+15)'(s1.a) * (PW+15)'(EXP_K);
		s2_d.y   = YW'(ak >> 12);
	end

	// Divider: one restoring step per stage; interpolation rides along.
	for (genvar k = 0; k < NQ; k++) begin : g_div
		item_t       prv;
		logic [DW:0] t;
		logic [16:0] ti, tn, dd;
		logic [23:0] dr;
		logic [YW-17:0] nsh;
		if (k == 0) begin : g_first
			assign prv = s2;
		end else begin : g_next
			assign prv = dv_s[k-1];
		end
		always_comb begin
			dv_d[k] = prv;
			t = {prv.rem, prv.lo[15]};
			dv_d[k].lo = {prv.lo[14:0], 1'b0};
			if (t >= {1'b0, prv.den}) begin
				dv_d[k].rem = DW'(t - {1'b0, prv.den});
				dv_d[k].q   = {prv.q[NQ-2:0], 1'b1};
			end else begin
				dv_d[k].rem = t[DW-1:0];
				dv_d[k].q   = {prv.q[NQ-2:0], 1'b0};
			end
			ti  = pow2_at({1'b0, prv.y[15:12]});
			tn  = pow2_at(5'({1'b0, prv.y[15:12]} + 5'd1));
			dd  = ti - tn;
			dr  = dd[11:0] * prv.y[11:0];
			nsh = prv.y[YW-1:16];
			if (k == 0) begin
				dv_d[k].m = ti - 17'(dr >> 12);
			end
			if (k == 1) begin
				dv_d[k].mul = (nsh > 16) ? 17'd0 : (prv.m >> nsh);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k] <= 1'b0;
			end else if (adv) begin
				dv_v[k] <= (k == 0) ? v_s2 : dv_v[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k] <= dv_d[k];
			end
		end
	end

	// Stage 3: pan bias and mix weights; mono runs with unity attenuation.
	logic [17:0] rb, lb;
	always_comb begin
		s3_d = dv_s[NQ-1];
		rb = dv_s[NQ-1].neg ? (18'(ONE_Q16) - 18'(dv_s[NQ-1].q))
		                    : (18'(ONE_Q16) + 18'(dv_s[NQ-1].q));
		lb = 18'(2 * ONE_Q16) - rb;
		if (dv_s[NQ-1].md[1]) begin
			s3_d.w0  = $signed({2'b00, lb});
			s3_d.w1  = '0;
			s3_d.w2  = '0;
			s3_d.w3  = $signed({2'b00, rb});
			s3_d.mul = 17'(ONE_Q16);
		end else begin
			s3_d.w0 = 20'sd327680 - $signed(20'(3 * {2'b00, rb}));
			s3_d.w1 = $signed({2'b00, rb}) - 20'sd65536;
			s3_d.w2 = $signed(20'(3 * {2'b00, rb})) - 20'sd65536;
			s3_d.w3 = 20'sd65536 - $signed({2'b00, rb});
		end
	end

	// Stage 4: the four weight products.
	always_comb begin
		s4_d = s3;
		s4_d.p0 = (SW+20)'(s3.xl) * (SW+20)'(s3.w0);
		s4_d.p1 = (SW+20)'(s3.xr) * (SW+20)'(s3.w1);
		s4_d.p2 = (SW+20)'(s3.xr) * (SW+20)'(s3.w2);
		s4_d.p3 = (SW+20)'(s3.xl) * (SW+20)'(s3.w3);
	end

	// Stage 5: sum and round; Q.17 weights for stereo, Q.16 gains for mono.
	logic signed [SW+21:0] suml, sumr;
	always_comb begin
		s5_d = s4;
		suml = (SW+22)'(s4.p0) + (SW+22)'(s4.p1);
		sumr = (SW+22)'(s4.p2) + (SW+22)'(s4.p3);
		if (s4.md[1]) begin
			s5_d.mll = MLW'((suml + (SW+22)'(32768)) >>> 16);
			s5_d.mlr = MLW'((sumr + (SW+22)'(32768)) >>> 16);
		end else begin
			s5_d.mll = MLW'((suml + (SW+22)'(65536)) >>> 17);
			s5_d.mlr = MLW'((sumr + (SW+22)'(65536)) >>> 17);
		end
	end

	// Stage 6: apply attenuation.
	always_comb begin
		s6_d = s5;
		s6_d.prl = PRW'(s5.mll) * PRW'($signed({1'b0, s5.mul}));
		s6_d.prr = PRW'(s5.mlr) * PRW'($signed({1'b0, s5.mul}));
	end

	// Stage 7: round, accumulate, saturate.
	localparam logic signed [YOW-1:0] SAT_HI = YOW'((longint'(1) << (SW-1)) - 1);
	localparam logic signed [YOW-1:0] SAT_LO = YOW'(-(longint'(1) << (SW-1)));
	logic signed [YOW-1:0] yl, yr;
	always_comb begin
		s7_d = s6;
		yl = YOW'((s6.prl + PRW'(32768)) >>> 16);
		yr = YOW'((s6.prr + PRW'(32768)) >>> 16);
		if (s6.md != MODE_STEREO_REPLACE) begin
			yl = yl + YOW'(s6.al);
			yr = yr + YOW'(s6.ar);
		end
		if (yl > SAT_HI)      s7_d.ol = SAT_HI[SW-1:0];
		else if (yl < SAT_LO) s7_d.ol = SAT_LO[SW-1:0];
		else                  s7_d.ol = yl[SW-1:0];
		if (yr > SAT_HI)      s7_d.orr = SAT_HI[SW-1:0];
		else if (yr < SAT_LO) s7_d.orr = SAT_LO[SW-1:0];
		else                  s7_d.orr = yr[SW-1:0];
	end

	// Valid bits: reset clears them, advance moves them with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= dv_v[NQ-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Payload: no reset, hold while stalled.
	always_ff @(posedge clk) begin
		if (adv) begin
			s1 <= s1_d;
			s2 <= s2_d;
			s3 <= s3_d;
			s4 <= s4_d;
			s5 <= s5_d;
			s6 <= s6_d;
			s7 <= s7_d;
		end
	end

	assign out_valid = v_s7;
	assign out_left  = s7.ol;
	assign out_right = s7.orr;
	assign last_out  = s7.last;

	// An empty output stage never refuses a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused while output stage empty");

	// The divider remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v[NQ-1] |-> (dv_s[NQ-1].rem < dv_s[NQ-1].den))
		else $error("divider remainder out of range");

	// A stall freezes the pipeline contents.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(dv_v[NQ-1]) && $stable(v_s4) && $stable(s7.ol)))
		else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

// ===== sim/stereo_pan_mixer_checker.sv =====
// Checker for the stereo pan mixer: watches input and output, predicts
// each output pair from the pan law and compares it. Depends on spm_pkg.
`timescale 1ns / 1ps
module stereo_pan_mixer_checker
	import spm_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_ready,
	input  wire  [1:0]        mode,
	input  wire  signed [15:0] pan_value,
	input  wire  signed [23:0] left_in,
	input  wire  signed [23:0] right_in,
	input  wire  signed [23:0] acc_left,
	input  wire  signed [23:0] acc_right,
	input  wire               last_in,
	input  wire               out_valid,
	input  wire               out_ready,
	input  wire  signed [23:0] out_left,
	input  wire  signed [23:0] out_right,
	input  wire               last_out,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic signed [23:0] lft;
		logic signed [23:0] rgt;
		logic               lst;
	} pair_t;

	pair_t mix_q[$];

	longint pow2_tbl[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
		46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

	function automatic longint round_shift(longint v, int s);
		longint t;
		t = v + (longint'(1) << (s - 1));
		return t >>> s;
	endfunction

	function automatic logic signed [23:0] clip(longint v);
		if (v > 8388607)
			return 24'sh7FFFFF;
		if (v < -8388608)
			return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic longint exp_gain(longint a);
		longint y, n, f, i, r, m;
		y = (a * EXP_K) >> 12;
		n = y >> 16;
		f = y & 16'hFFFF;
		i = f >> 12;
		r = f & 12'hFFF;
		m = pow2_tbl[i] - (((pow2_tbl[i] - pow2_tbl[i + 1]) * r) >> 12);
		if (n > 16)
			return 0;
		return m >>> n;
	endfunction

	function automatic pair_t pan_mix(logic [1:0] md, longint p, longint xl, longint xr,
		longint al, longint ar, logic lst);
		longint a, den, q, rb, yl, yr, g, ml, mr;
		pair_t res;
		a = (p < 0) ? -p : p;
		den = 4096 + a;
		q = ((a << 16) + (den >> 1)) / den;
		rb = (p < 0) ? ONE_Q16 - q : ONE_Q16 + q;
		if (md[1]) begin
			yl = round_shift(xl * (2 * ONE_Q16 - rb), 16);
			yr = round_shift(xl * rb, 16);
		end else begin
			g = exp_gain(a);
			ml = round_shift(xl * (5 * ONE_Q16 - 3 * rb) + xr * (rb - ONE_Q16), 17);
			mr = round_shift(xr * (3 * rb - ONE_Q16) + xl * (ONE_Q16 - rb), 17);
			yl = round_shift(ml * g, 16);
			yr = round_shift(mr * g, 16);
		end
		if (md != MODE_STEREO_REPLACE) begin
			yl += al;
			yr += ar;
		end
		res.lft = clip(yl);
		res.rgt = clip(yr);
		res.lst = lst;
		return res;
	endfunction

	assign pending = mix_q.size();

	always @(posedge clk or negedge arst_n) begin
		pair_t want;
		if (!arst_n) begin
			errors <= 0;
			mix_q.delete();
		end else begin
			if (in_valid && in_ready)
				mix_q.push_back(pan_mix(mode, pan_value, left_in, right_in,
					acc_left, acc_right, last_in));
			if (out_valid && out_ready) begin
				if (mix_q.size() == 0) begin
					$display("%0t: unexpected result L=%0d R=%0d", $time, out_left, out_right);
					errors <= errors + 1;
				end else begin
					want = mix_q.pop_front();
					if (want.lft !== out_left || want.rgt !== out_right
						|| want.lst !== last_out) begin
						$display("%0t: mismatch expected L=%0d R=%0d last=%0b got L=%0d R=%0d last=%0b",
							$time, want.lft, want.rgt, want.lst, out_left, out_right, last_out);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== sim/stereo_pan_mixer_test.sv =====
// Testbench top for the stereo pan mixer: drives requests with random gaps and
// output stalls; stereo_pan_mixer_checker does the prediction. Depends on spm_pkg.
`timescale 1ns / 1ps
module stereo_pan_mixer_test;
	import spm_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = MODE_STEREO_REPLACE;
	logic signed [15:0] pan_value = '0;
	logic signed [23:0] left_in = '0, right_in = '0, acc_left = '0, acc_right = '0;
	logic last_in = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [23:0] out_left, out_right;
	logic last_out;
	int errors, pending;
	int cycles = 0;
	// idle chance in percent; zero during the calm stretch
	int idle_pct = 36;

	always #10 clk = ~clk;

	stereo_pan_mixer i_dut (.*);

	stereo_pan_mixer_checker i_check (.*);

	// Stall the output side at random.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= idle_pct);

	// Stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Pick a sample: extremes now and then, otherwise any value.
	function automatic logic [23:0] pick_sample();
		case ($urandom_range(7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			default: return 24'($urandom());
		endcase
	endfunction

	// Pan within one unit of center half the time so the exp tail and divider get use.
	function automatic logic [15:0] pick_pan();
		case ($urandom_range(3))
			0: return 16'($urandom());
			1: return 16'($urandom_range(0, 8192) - 4096);
			2: return 16'($urandom_range(0, 65535) - 32768);
			default: return 16'($urandom_range(0, 1024) - 512);
		endcase
	endfunction

	// Present one request, hold it until taken, then maybe idle.
	task automatic send(logic [1:0] md, logic [15:0] p, logic [23:0] xl, logic [23:0] xr,
		logic [23:0] al, logic [23:0] ar, logic lst);
		mode <= md;
		pan_value <= p;
		left_in <= xl;
		right_in <= xr;
		acc_left <= al;
		acc_right <= ar;
		last_in <= lst;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	initial begin
		logic [1:0] md;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pan extremes, full-scale samples, every mode code.
		send(MODE_STEREO_REPLACE, 16'h0000, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 1'b0);
		send(MODE_STEREO_REPLACE, 16'h7FFF, 24'h7FFFFF, 24'h7FFFFF, 24'h0, 24'h0, 1'b1);
		send(MODE_STEREO_REPLACE, 16'h8000, 24'h800000, 24'h800000, 24'h0, 24'h0, 1'b0);
		send(MODE_STEREO_REPLACE, 16'hF000, 24'h400000, 24'hC00000, 24'h0, 24'h0, 1'b0);
		send(MODE_STEREO_ACC, 16'h1000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
		send(MODE_STEREO_ACC, 16'hFFFF, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 1'b0);
		send(MODE_STEREO_ACC, 16'h0001, 24'h123456, 24'hFEDCBA, 24'h7FFFFF, 24'h800000, 1'b0);
		send(MODE_MONO_ACC, 16'h7FFF, 24'h7FFFFF, 24'h123456, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
		send(MODE_MONO_ACC, 16'h8000, 24'h800000, 24'hFFFFFF, 24'h800000, 24'h800000, 1'b1);
		send(MODE_MONO_ACC, 16'h0000, 24'h7FFFFF, 24'h000000, 24'h0, 24'h0, 1'b0);
		send(MODE_MONO_ACC_ALT, 16'h2000, 24'h7FFFFF, 24'hABCDEF, 24'h0, 24'h0, 1'b0);
		send(MODE_MONO_ACC_ALT, 16'hE000, 24'h800000, 24'h7FFFFF, 24'h100, 24'hFFFF00, 1'b1);

		// Random: a calm stretch with no idling in the middle.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			idle_pct = (k >= 600 && k < 900) ? 0 : 36;
			md = 2'($urandom_range(3));
			send(md, pick_pan(), pick_sample(), pick_sample(), pick_sample(), pick_sample(),
				1'($urandom_range(1)));
		end
		in_valid <= 1'b0;
		idle_pct = 36;

		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/spm_pkg.sv
sv/stereo_pan_mixer.sv
sim/stereo_pan_mixer_checker.sv
sim/stereo_pan_mixer_test.sv
